// ===== rtl/text_console_writer_macros.svh =====
// Assertion helpers for the checker file.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Clocked check, masked while reset is high.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int KIND_W  = 2;
   localparam int COORD_W = 8;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = 16;

   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_CR           = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF           = 8'h0A;
   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [CELL_W-1:0] BLANK_CELL      = 16'h0020;
   localparam logic [CELL_W-1:0] ZERO_CELL       = 16'h0000;

   typedef struct packed {
      logic load_item;
      logic move_cursor;
      logic finish_scroll;
      logic calc_prow;
      logic draw;
      logic read_issue;
      logic read_capture;
      logic sweep_clear;
      logic sweep_blank;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              printable;
      logic              need_scroll;
      logic              in_range;
      logic              clear_last;
      logic              row_last;
      logic              rsp_free;
   } ctrl_status_type;

endpackage

// ===== rtl/tcw_req_if.sv =====
interface tcw_req_if;
   import tcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CHAR_W-1:0]  char_byte;
   logic [COORD_W-1:0] read_col;
   logic [COORD_W-1:0] read_row;

   modport source (output valid, kind, char_byte, read_col, read_row, input ready);
   modport sink   (input valid, kind, char_byte, read_col, read_row, output ready);
endinterface

// ===== rtl/tcw_rsp_if.sv =====
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cursor_col;
   logic [COORD_W-1:0] cursor_row;
   logic [CELL_W-1:0]  read_data;
   logic               scrolled;
   logic               drew_cell;

   modport source (output valid, cursor_col, cursor_row, read_data, scrolled, drew_cell,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, read_data, scrolled, drew_cell,
                   output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2400
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/tcw_datapath.sv =====
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcw_pkg::ctrl_cmd_type          cmd,
   output tcw_pkg::ctrl_status_type       status,
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0]     csr_write_data,
   input  logic [tcw_pkg::KIND_W-1:0]     req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_byte,
   input  logic [tcw_pkg::COORD_W-1:0]    req_read_col,
   input  logic [tcw_pkg::COORD_W-1:0]    req_read_row,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [tcw_pkg::COORD_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::COORD_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::CELL_W-1:0]     rsp_read_data,
   output logic                           rsp_scrolled,
   output logic                           rsp_drew_cell
);
   import tcw_pkg::*;

   localparam int DEPTH  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [CHAR_W-1:0]  ch_ff, ch_in;
   logic [COORD_W-1:0] rcol_ff, rcol_in;
   logic [COORD_W-1:0] rrow_ff, rrow_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] top_ff, top_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [COORD_W-1:0] prow_ff, prow_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [CELL_W-1:0]  rdata_ff, rdata_in;
   logic               scrolled_ff, scrolled_in;
   logic               drew_ff, drew_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in;
   logic [CELL_W-1:0]  out_rdata_ff, out_rdata_in;
   logic               out_scrolled_ff, out_scrolled_in;
   logic               out_drew_ff, out_drew_in;

   logic               printable, is_cr, col_full, need_wrap, on_last_row;
   logic               clear_last, row_last, draw_ok;
   logic [COORD_W-1:0] prow_src, acc_col;
   logic [COORD_W:0]   prow_sum, prow_wrap;
   logic [ADDR_W-1:0]  cell_addr, blank_addr;
   logic [ADDR_W-1:0]  ram_addr;
   logic               ram_we;
   logic [CELL_W-1:0]  ram_wdata, ram_rdata;

   assign printable   = ch_ff >= FIRST_PRINTABLE;
   assign is_cr       = ch_ff == CH_CR;
   assign col_full    = col_ff >= COORD_W'(COLUMNS);
   assign need_wrap   = !is_cr && (ch_ff == CH_LF || (printable && col_full));
   assign on_last_row = row_ff >= COORD_W'(ROWS - 1);
   assign draw_ok     = !col_full;
   assign clear_last  = cnt_ff == ADDR_W'(DEPTH - 1);
   assign row_last    = cnt_ff == ADDR_W'(COLUMNS - 1);

   // screen row to ring row: both terms below ROWS, so one subtract at most
   assign prow_src  = (kind_ff == KIND_READ) ? rrow_ff : row_ff;
   assign acc_col   = (kind_ff == KIND_READ) ? rcol_ff : col_ff;
   assign prow_sum  = {1'b0, prow_src} + {1'b0, top_ff};
   assign prow_wrap = (prow_sum >= (COORD_W + 1)'(ROWS)) ? prow_sum - (COORD_W + 1)'(ROWS)
                                                         : prow_sum;

   assign cell_addr  = ADDR_W'(prow_ff) * ADDR_W'(COLUMNS) + ADDR_W'(acc_col);
   assign blank_addr = ADDR_W'(top_ff) * ADDR_W'(COLUMNS) + cnt_ff;

   always_comb begin
      ram_we = cmd.sweep_clear | cmd.sweep_blank | (cmd.draw & draw_ok);
      priority if (cmd.sweep_clear) begin
         ram_addr  = cnt_ff;
         ram_wdata = ZERO_CELL;
      end else if (cmd.sweep_blank) begin
         ram_addr  = blank_addr;
         ram_wdata = BLANK_CELL;
      end else begin
         ram_addr  = cell_addr;
         ram_wdata = {attr_ff, ch_ff};
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .re    (cmd.read_issue),
      .rdata (ram_rdata)
   );

   always_comb begin
      kind_in         = kind_ff;
      ch_in           = ch_ff;
      rcol_in         = rcol_ff;
      rrow_in         = rrow_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      top_in          = top_ff;
      attr_in         = attr_ff;
      prow_in         = prow_ff;
      cnt_in          = cnt_ff;
      rdata_in        = rdata_ff;
      scrolled_in     = scrolled_ff;
      drew_in         = drew_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      out_rdata_in    = out_rdata_ff;
      out_scrolled_in = out_scrolled_ff;
      out_drew_in     = out_drew_ff;

      if (csr_write_enable) begin
         attr_in = csr_write_data;
      end
      if (cmd.load_item) begin
         kind_in     = req_kind;
         ch_in       = req_char_byte;
         rcol_in     = req_read_col;
         rrow_in     = req_read_row;
         rdata_in    = ZERO_CELL;
         scrolled_in = 1'b0;
         drew_in     = 1'b0;
      end
      if (cmd.move_cursor) begin
         if (is_cr || need_wrap) begin
            col_in = '0;
         end
         if (need_wrap && !on_last_row) begin
            row_in = row_ff + 1'b1;
         end
      end
      if (cmd.finish_scroll) begin
         top_in      = (top_ff == COORD_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
         row_in      = COORD_W'(ROWS - 1);
         scrolled_in = 1'b1;
      end
      if (cmd.calc_prow) begin
         prow_in = prow_wrap[COORD_W-1:0];
      end
      if (cmd.draw && draw_ok) begin
         col_in  = col_ff + 1'b1;
         drew_in = 1'b1;
      end
      if (cmd.read_capture) begin
         rdata_in = ram_rdata;
      end
      if (cmd.sweep_clear) begin
         cnt_in = clear_last ? '0 : cnt_ff + 1'b1;
      end else if (cmd.sweep_blank) begin
         cnt_in = row_last ? '0 : cnt_ff + 1'b1;
      end
      if (cmd.load_result) begin
         out_col_in      = col_ff;
         out_row_in      = row_ff;
         out_rdata_in    = rdata_ff;
         out_scrolled_in = scrolled_ff;
         out_drew_in     = drew_ff;
      end

      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff         <= kind_in;
      ch_ff           <= ch_in;
      rcol_ff         <= rcol_in;
      rrow_ff         <= rrow_in;
      prow_ff         <= prow_in;
      rdata_ff        <= rdata_in;
      scrolled_ff     <= scrolled_in;
      drew_ff         <= drew_in;
      out_col_ff      <= out_col_in;
      out_row_ff      <= out_row_in;
      out_rdata_ff    <= out_rdata_in;
      out_scrolled_ff <= out_scrolled_in;
      out_drew_ff     <= out_drew_in;
   end

   always_comb begin
      status.kind        = kind_ff;
      status.printable   = printable;
      status.need_scroll = need_wrap && on_last_row;
      status.in_range    = (rcol_ff < COORD_W'(COLUMNS)) && (rrow_ff < COORD_W'(ROWS));
      status.clear_last  = clear_last;
      status.row_last    = row_last;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_read_data  = out_rdata_ff;
   assign rsp_scrolled   = out_scrolled_ff;
   assign rsp_drew_cell  = out_drew_ff;
endmodule

// ===== rtl/tcw_controller.sv =====
module tcw_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcw_pkg::ctrl_status_type status,
   output tcw_pkg::ctrl_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_ADDR,
      S_DRAW,
      S_READ,
      S_READ_WAIT,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (status.kind)
               KIND_CHAR: begin
                  cmd.move_cursor = 1'b1;
                  priority if (status.need_scroll) begin
                     state_in = S_SCROLL;
                  end else if (status.printable) begin
                     state_in = S_ADDR;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               KIND_READ: begin
                  cmd.calc_prow = 1'b1;
                  state_in      = status.in_range ? S_READ : S_DONE;
               end
               KIND_CLEAR: begin
                  state_in = S_CLEAR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCROLL: begin
            cmd.sweep_blank = 1'b1;
            if (status.row_last) begin
               cmd.finish_scroll = 1'b1;
               state_in          = status.printable ? S_ADDR : S_DONE;
            end
         end
         S_ADDR: begin
            cmd.calc_prow = 1'b1;
            state_in      = S_DRAW;
         end
         S_DRAW: begin
            cmd.draw = 1'b1;
            state_in = S_DONE;
         end
         S_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = S_DONE;
         end
         S_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/text_console_writer.sv =====
// Per item: a char moves the cursor, blanks a row to scroll when needed and draws if printable;
// a read fetches one cell when in range; a clear zeros every cell; an unused kind goes
// straight to the result.
// One item is in work at a time; the next is taken only after the result of the last has
// been loaded for output.
// Reset is synchronous; afterwards the cell memory is zeroed one cell a cycle, all
// COLUMNS*ROWS cells, and until that ends no item is accepted (attribute writes still are).
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   tcw_req_if.sink                    req_if,
   tcw_rsp_if.source                  rsp_if,
   input  logic                       csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_if.kind),
      .req_char_byte    (req_if.char_byte),
      .req_read_col     (req_if.read_col),
      .req_read_row     (req_if.read_row),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_cursor_col   (rsp_if.cursor_col),
      .rsp_cursor_row   (rsp_if.cursor_row),
      .rsp_read_data    (rsp_if.read_data),
      .rsp_scrolled     (rsp_if.scrolled),
      .rsp_drew_cell    (rsp_if.drew_cell)
   );
endmodule

// ===== rtl/tcw_checker.sv =====
`include "text_console_writer_macros.svh"

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 30
) (
   input logic       clock,
   input logic       reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if
);
   import tcw_pkg::*;

   // held item must not change under a stall
   `TCW_ASSERT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.cursor_col) && $stable(rsp_if.read_data), "result item dropped or changed while stalled")

   `TCW_ASSERT(a_cursor_bounds, clock, reset, rsp_if.valid |-> (rsp_if.cursor_col <= COORD_W'(COLUMNS)) && (rsp_if.cursor_row < COORD_W'(ROWS)), "cursor out of bounds")

   // a scroll leaves the cursor on the bottom row near the left edge
   `TCW_ASSERT(a_scroll_pos, clock, reset, rsp_if.valid && rsp_if.scrolled |-> (rsp_if.cursor_row == COORD_W'(ROWS - 1)) && (rsp_if.cursor_col <= COORD_W'(1)), "scroll left cursor off bottom row")

   `TCW_ASSERT(a_draw_fields, clock, reset, rsp_if.valid && rsp_if.drew_cell |-> (rsp_if.cursor_col != '0) && (rsp_if.read_data == '0), "drawn item has bad cursor or read data")

   `TCW_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_if.valid && !req_if.ready, "activity straight after reset")
endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
